// ===== hdl/ccs_pkg.sv =====
// ccs_pkg: shared types and character constants for the comment stripper.
// Used by ccs_scan, ccs_outq and c_comment_stripper; depends on nothing.

package ccs_pkg;

  localparam logic [7:0] CharSlash = 8'h2F;
  localparam logic [7:0] CharStar  = 8'h2A;
  localparam logic [7:0] CharNl    = 8'h0A;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharQuote = 8'h22;

  typedef enum logic [1:0] {
    ModeNormal = 2'd0,
    ModeString = 2'd1,
    ModeLine   = 2'd2,
    ModeBlock  = 2'd3
  } scan_mode_e;

  // One output beat.
  typedef struct packed {
    logic [7:0] char_out;
    logic       run_last;
    logic       text_last;
  } beat_t;

  // Everything one input byte produces: up to two beats, in order.
  typedef struct packed {
    logic [1:0] num;
    beat_t      beat1;
    beat_t      beat0;
  } step_t;

endpackage

// ===== hdl/c_comment_stripper.sv =====
// c_comment_stripper: blanks C comments in a byte stream, strings untouched.
// Output: an accepted byte's beats are registered into the result queue behind any still waiting.
// Throughput: one input beat per cycle while the queue holds at most one beat;
//   tready is low while two or more beats wait in the three-entry result queue.
// Reset (rst_ni, async, active low) clears scan mode, held mark and queue count.
// Depends on ccs_pkg, ccs_scan, ccs_outq.

module c_comment_stripper (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] char_in
  input  logic       s_axis_tlast_i,   // end_of_text
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] char_out
  output logic       m_axis_tlast_o,   // run_last
  output logic       m_axis_tuser_o    // [0] text_last
);

  logic           accept;
  logic           in_ready;
  ccs_pkg::step_t step;
  ccs_pkg::beat_t head;

  assign accept          = s_axis_tvalid_i && in_ready;
  assign s_axis_tready_o = in_ready;

  ccs_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .char_i   (s_axis_tdata_i),
    .eot_i    (s_axis_tlast_i),
    .step_o   (step)
  );

  ccs_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .step_i      (step),
    .in_ready_o  (in_ready),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_beat_o  (head)
  );

  assign m_axis_tdata_o = head.char_out;
  assign m_axis_tlast_o = head.run_last;
  assign m_axis_tuser_o = head.text_last;

endmodule

// ===== hdl/ccs_scan.sv =====
// ccs_scan: scan state (mode and held mark) and the per-byte step logic.
// Depends on ccs_pkg.

module ccs_scan (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       char_i,
  input  logic             eot_i,
  output ccs_pkg::step_t   step_o
);

  ccs_pkg::scan_mode_e mode_q, mode_d;
  logic                held_q, held_d;
  ccs_pkg::step_t      step;

  always_comb begin
    mode_d = mode_q;
    held_d = held_q;
    step   = '0;
    case (mode_q)
      ccs_pkg::ModeNormal: begin
        if (held_q) begin
          held_d = 1'b0;
          step.num = 2'd2;
          if (char_i == ccs_pkg::CharSlash || char_i == ccs_pkg::CharStar) begin
            step.beat0.char_out = ccs_pkg::CharSpace;
            step.beat1.char_out = ccs_pkg::CharSpace;
            mode_d = (char_i == ccs_pkg::CharSlash) ? ccs_pkg::ModeLine
                                                    : ccs_pkg::ModeBlock;
          end else begin
            // the held slash was just a divide; emit it, then the byte
            step.beat0.char_out = ccs_pkg::CharSlash;
            step.beat1.char_out = char_i;
            if (char_i == ccs_pkg::CharQuote) mode_d = ccs_pkg::ModeString;
          end
        end else if (char_i == ccs_pkg::CharSlash) begin
          held_d = 1'b1;
        end else begin
          step.num = 2'd1;
          step.beat0.char_out = char_i;
          if (char_i == ccs_pkg::CharQuote) mode_d = ccs_pkg::ModeString;
        end
      end
      ccs_pkg::ModeString: begin
        step.num = 2'd1;
        step.beat0.char_out = char_i;
        if (char_i == ccs_pkg::CharQuote) mode_d = ccs_pkg::ModeNormal;
      end
      ccs_pkg::ModeLine: begin
        step.num = 2'd1;
        if (char_i == ccs_pkg::CharNl) begin
          step.beat0.char_out = ccs_pkg::CharNl;
          mode_d = ccs_pkg::ModeNormal;
        end else begin
          step.beat0.char_out = ccs_pkg::CharSpace;
        end
      end
      ccs_pkg::ModeBlock: begin
        step.num = 2'd1;
        if (char_i == ccs_pkg::CharNl) begin
          step.beat0.char_out = ccs_pkg::CharNl;
          held_d = 1'b0;
        end else begin
          step.beat0.char_out = ccs_pkg::CharSpace;
          if (held_q && char_i == ccs_pkg::CharSlash) begin
            held_d = 1'b0;
            mode_d = ccs_pkg::ModeNormal;
          end else begin
            held_d = (char_i == ccs_pkg::CharStar);
          end
        end
      end
      default: begin
        step.num = 2'd0;
      end
    endcase

    if (eot_i) begin
      // flush a pending slash; only possible when nothing else was emitted
      if (mode_d == ccs_pkg::ModeNormal && held_d) begin
        step.num = 2'd1;
        step.beat0.char_out = ccs_pkg::CharSlash;
      end
      mode_d = ccs_pkg::ModeNormal;
      held_d = 1'b0;
    end

    if (step.num == 2'd1) begin
      step.beat0.run_last  = 1'b1;
      step.beat0.text_last = eot_i;
    end else if (step.num == 2'd2) begin
      step.beat1.run_last  = 1'b1;
      step.beat1.text_last = eot_i;
    end
  end

  assign step_o = step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ccs_pkg::ModeNormal;
      held_q <= 1'b0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      held_q <= held_d;
    end
  end

`ifndef ASSERT_OFF
  a_held_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q |-> (mode_q == ccs_pkg::ModeNormal || mode_q == ccs_pkg::ModeBlock))
    else $error("held mark set outside normal text or block comment");
  a_eot_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && eot_i) |-> (step.num != 2'd0))
    else $error("end of text produced no beat");
  a_eot_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && eot_i) |=> (mode_q == ccs_pkg::ModeNormal && !held_q))
    else $error("scan state not back to normal after end of text");
`endif

endmodule

// ===== hdl/ccs_outq.sv =====
// ccs_outq: three-entry result queue; head entry drives the output stream.
// Depends on ccs_pkg.

module ccs_outq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ccs_pkg::step_t step_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ccs_pkg::beat_t out_beat_o
);

  ccs_pkg::beat_t ent_q [3];
  ccs_pkg::beat_t ent_d [3];
  logic [1:0]     cnt_q, cnt_d;
  logic [1:0]     base;
  logic [1:0]     num;
  logic           pop;

  assign pop         = (cnt_q != 2'd0) && out_ready_i;
  assign in_ready_o  = (cnt_q <= 2'd1);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_beat_o  = ent_q[0];
  assign num         = push_i ? step_i.num : 2'd0;
  assign base        = cnt_q - {1'b0, pop};
  assign cnt_d       = base + num;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (pop && i < 2) ent_d[i] = ent_q[(i < 2) ? i + 1 : i];
      else              ent_d[i] = ent_q[i];
      // a push lands behind what survives the pop
      if (num != 2'd0 && base == 2'(i))                ent_d[i] = step_i.beat0;
      if (num == 2'd2 && (base + 2'd1) == 2'(i))       ent_d[i] = step_i.beat1;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) ent_q[i] <= ent_d[i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q <= 2'd1))
    else $error("push into queue without room for two beats");
  a_fill_three: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && step_i.num == 2'd2 && cnt_q == 2'd1 && !pop) |=> (cnt_q == 2'd3))
    else $error("queue count wrong after double push");
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push_i) |=> (cnt_q == $past(cnt_q) - 2'd1))
    else $error("queue count wrong after pop");
`endif

endmodule
